[rtl/core/stc_pkg.sv]
// Shared constants and register indexes for the slice time calculator.
// No dependencies; every other file imports this package.
`default_nettype none
package stc_pkg;

    localparam int TIME_BITS     = 48;
    localparam int MAX_SLICES    = 4096;
    localparam int PORTION_LIMIT = 256;

    localparam int PER_W   = 36;
    localparam int CNT_W   = 13;
    localparam int POR_W   = 9;
    localparam int OFF_W   = 32;
    localparam int SN_W    = 24;
    localparam int NL_W    = 21;
    localparam int CSL_W   = 12;
    localparam int CLS_W   = 20;
    localparam int ABSL_W  = 56;
    localparam int START_W = 60;

    localparam int DIV_NW     = TIME_BITS;
    localparam int DIV_DW     = PER_W;
    localparam int DIV_STAGES = DIV_NW;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = PER_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECTED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOGIC_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PORTION_CNT  = 3'd4;

endpackage
`default_nettype wire

[rtl/core/stc_query_if.sv]
// Query channel: valid/ready handshake with timestamp, offset and slice number.
// Depends on stc_pkg.
`default_nettype none
interface stc_query_if;
    import stc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] time_ps;
    logic [OFF_W-1:0]     offset_ps;
    logic [SN_W-1:0]      slice_number;

    modport source (output valid, time_ps, offset_ps, slice_number, input ready);
    modport sink   (input valid, time_ps, offset_ps, slice_number, output ready);
endinterface
`default_nettype wire

[rtl/core/stc_result_if.sv]
// Result channel: valid/ready handshake with the schedule lookup fields.
// Depends on stc_pkg.
`default_nettype none
interface stc_result_if;
    import stc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [PER_W-1:0]     time_in_slice;
    logic [TIME_BITS-1:0] abs_slice;
    logic [CSL_W-1:0]     cycle_slice;
    logic [ABSL_W-1:0]    abs_logic_slice;
    logic [CLS_W-1:0]     cycle_logic_slice;
    logic                 in_reconfig;
    logic                 crosses_slice;
    logic [START_W-1:0]   slice_start_ps;
    logic [START_W-1:0]   logic_start_ps;
    logic [CSL_W-1:0]     wrapped_slice;
    logic [CLS_W-1:0]     wrapped_logic_slice;

    modport source (output valid, time_in_slice, abs_slice, cycle_slice, abs_logic_slice,
                    cycle_logic_slice, in_reconfig, crosses_slice, slice_start_ps,
                    logic_start_ps, wrapped_slice, wrapped_logic_slice, input ready);
    modport sink   (input valid, time_in_slice, abs_slice, cycle_slice, abs_logic_slice,
                    cycle_logic_slice, in_reconfig, crosses_slice, slice_start_ps,
                    logic_start_ps, wrapped_slice, wrapped_logic_slice, output ready);
endinterface
`default_nettype wire

[rtl/core/stc_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on stc_pkg; the divisor must stay stable while items are in flight.
`default_nettype none
module stc_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [stc_pkg::DIV_NW-1:0] i_num,
    input  wire logic [stc_pkg::DIV_DW-1:0] i_den,
    output logic      [stc_pkg::DIV_NW-1:0] o_quo,
    output logic      [stc_pkg::DIV_DW-1:0] o_rem
);
    import stc_pkg::*;

    logic [DIV_NW-1:0] r_word [DIV_STAGES];
    logic [DIV_DW-1:0] r_rem  [DIV_STAGES];
    logic [DIV_NW-1:0] n_word [DIV_STAGES];
    logic [DIV_DW-1:0] n_rem  [DIV_STAGES];
    logic [DIV_NW-1:0] w_src_word [DIV_STAGES];
    logic [DIV_DW-1:0] w_src_rem  [DIV_STAGES];

    assign w_src_word[0] = i_num;
    assign w_src_rem[0]  = '0;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DIV_DW:0] w_sh;
        logic [DIV_DW:0] w_diff;
        logic            w_ge;
        if (k > 0) begin : g_link
            assign w_src_word[k] = r_word[k-1];
            assign w_src_rem[k]  = r_rem[k-1];
        end
        // shift in the next dividend bit, subtract when it fits
        assign w_sh      = {w_src_rem[k], w_src_word[k][DIV_NW-1]};
        assign w_diff    = w_sh - {1'b0, i_den};
        assign w_ge      = w_sh >= {1'b0, i_den};
        assign n_rem[k]  = w_ge ? w_diff[DIV_DW-1:0] : w_sh[DIV_DW-1:0];
        assign n_word[k] = {w_src_word[k][DIV_NW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_word[k] <= n_word[k];
                r_rem[k]  <= n_rem[k];
            end
        end
    end

    assign o_quo = r_word[DIV_STAGES-1];
    assign o_rem = r_rem[DIV_STAGES-1];
endmodule
`default_nettype wire

[rtl/core/slice_time_calculator_unit.sv]
// Top level of the slice time calculator: config registers and lookup pipeline.
// Depends on stc_pkg, stc_query_if, stc_result_if and stc_div.
//
// Usage: each query transfer on i_query (time, offset, slice number) yields
// exactly one result transfer on o_result, in order. Schedule registers are
// written through i_cfg_we/i_cfg_idx/i_cfg_data while no query is in flight;
// indexes beyond the list are ignored.
// Pipeline: two banks of bit-per-stage dividers (TIME_BITS stages each), then the output register.
// Throughput: one query per cycle; i_query.ready is high whenever the output
// register is empty or being taken.
// Stall: when o_result is valid and not ready, the whole pipeline holds in
// place and i_query.ready drops; nothing is lost or repeated.
// Reset: synchronous on i_rst_n; clears all valid bits and returns the
// registers to slice period 1000000, connected 900000, logic period 300000,
// 8 slices and 1 portion.
`default_nettype none
module slice_time_calculator_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [stc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [stc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    stc_query_if.sink                          i_query,
    stc_result_if.source                       o_result
);
    import stc_pkg::*;

    localparam int D        = DIV_STAGES;
    localparam int VLD_LAST = 2 * D;
    localparam int LLO_W    = POR_W + PER_W;

    typedef struct packed {
        logic [OFF_W-1:0] offset_ps;
        logic [SN_W-1:0]  slice_number;
    } t_side_a;

    typedef struct packed {
        logic [TIME_BITS-1:0] abs_slice;
        logic [PER_W-1:0]     time_in_slice;
        logic                 in_reconfig;
        logic                 crosses_slice;
        logic [START_W-1:0]   slice_start;
        logic [START_W-1:0]   lstart_hi;
        logic [LLO_W-1:0]     lstart_lo;
        logic [CSL_W-1:0]     wrapped_slice;
        logic [CLS_W-1:0]     wrapped_logic;
    } t_side_b;

    // configuration registers
    logic [PER_W-1:0] r_slice_period;
    logic [PER_W-1:0] r_connected;
    logic [PER_W-1:0] r_logic_period;
    logic [CNT_W-1:0] r_slice_count;
    logic [POR_W-1:0] r_portion_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_period  <= PER_W'(1000000);
            r_connected     <= PER_W'(900000);
            r_logic_period  <= PER_W'(300000);
            r_slice_count   <= CNT_W'(8);
            r_portion_count <= POR_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SLICE_PERIOD: r_slice_period  <= i_cfg_data[PER_W-1:0];
                CFG_CONNECTED:    r_connected     <= i_cfg_data[PER_W-1:0];
                CFG_LOGIC_PERIOD: r_logic_period  <= i_cfg_data[PER_W-1:0];
                CFG_SLICE_COUNT:  r_slice_count   <= i_cfg_data[CNT_W-1:0];
                CFG_PORTION_CNT:  r_portion_count <= i_cfg_data[POR_W-1:0];
                default: ;
            endcase
        end
    end

    // effective schedule values: zero becomes one, counts saturate
    logic [PER_W-1:0] w_period;
    logic [PER_W-1:0] w_lperiod;
    logic [CNT_W-1:0] w_nsl;
    logic [POR_W-1:0] w_npo;
    logic [NL_W-1:0]  w_nlogic;

    always_comb begin
        w_period  = (r_slice_period == '0) ? PER_W'(1) : r_slice_period;
        w_lperiod = (r_logic_period == '0) ? PER_W'(1) : r_logic_period;
        if (r_slice_count == '0) begin
            w_nsl = CNT_W'(1);
        end else if (int'(r_slice_count) > MAX_SLICES) begin
            w_nsl = CNT_W'(MAX_SLICES);
        end else begin
            w_nsl = r_slice_count;
        end
        if (r_portion_count == '0) begin
            w_npo = POR_W'(1);
        end else if (int'(r_portion_count) > PORTION_LIMIT) begin
            w_npo = POR_W'(PORTION_LIMIT);
        end else begin
            w_npo = r_portion_count;
        end
        w_nlogic = NL_W'(w_nsl) * NL_W'(w_npo);
    end

    // pipeline control: advance all stages together
    logic [VLD_LAST:0] r_vld;
    logic              w_adv;

    assign w_adv         = !r_vld[VLD_LAST] || o_result.ready;
    assign i_query.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[VLD_LAST-1:0], i_query.valid};
        end
    end

    // first divider bank: time by period, slice number by the three counts
    logic [DIV_NW-1:0] w_ta_quo, w_sp_quo, w_sc_quo, w_sl_quo;
    logic [DIV_DW-1:0] w_ta_rem, w_sp_rem, w_sc_rem, w_sl_rem;
    logic [DIV_NW-1:0] w_sn_ext;

    assign w_sn_ext = DIV_NW'(i_query.slice_number);

    stc_div u_div_time (
        .i_clk (i_clk), .i_en (w_adv),
        .i_num (i_query.time_ps), .i_den (w_period),
        .o_quo (w_ta_quo), .o_rem (w_ta_rem)
    );
    stc_div u_div_sn_por (
        .i_clk (i_clk), .i_en (w_adv),
        .i_num (w_sn_ext), .i_den (DIV_DW'(w_npo)),
        .o_quo (w_sp_quo), .o_rem (w_sp_rem)
    );
    stc_div u_div_sn_cnt (
        .i_clk (i_clk), .i_en (w_adv),
        .i_num (w_sn_ext), .i_den (DIV_DW'(w_nsl)),
        .o_quo (w_sc_quo), .o_rem (w_sc_rem)
    );
    stc_div u_div_sn_log (
        .i_clk (i_clk), .i_en (w_adv),
        .i_num (w_sn_ext), .i_den (DIV_DW'(w_nlogic)),
        .o_quo (w_sl_quo), .o_rem (w_sl_rem)
    );

    t_side_a r_side_a [D];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side_a[0] <= '{offset_ps: i_query.offset_ps, slice_number: i_query.slice_number};
            for (int k = 1; k < D; k++) begin
                r_side_a[k] <= r_side_a[k-1];
            end
        end
    end

    // products and flags once the time is split
    t_side_b          n_side_b;
    logic [PER_W:0]   w_rel_off;

    always_comb begin
        // the sum leaves the slice exactly when it reaches the period
        w_rel_off              = {1'b0, w_ta_rem} + (PER_W+1)'(r_side_a[D-1].offset_ps);
        n_side_b.abs_slice     = w_ta_quo;
        n_side_b.time_in_slice = w_ta_rem;
        n_side_b.in_reconfig   = w_ta_rem > r_connected;
        n_side_b.crosses_slice = w_rel_off >= {1'b0, w_period};
        n_side_b.slice_start   = START_W'(r_side_a[D-1].slice_number) * START_W'(w_period);
        n_side_b.lstart_hi     = START_W'(w_sp_quo[SN_W-1:0]) * START_W'(w_period);
        n_side_b.lstart_lo     = LLO_W'(w_sp_rem[POR_W-1:0]) * LLO_W'(w_lperiod);
        n_side_b.wrapped_slice = w_sc_rem[CSL_W-1:0];
        n_side_b.wrapped_logic = w_sl_rem[CLS_W-1:0];
    end

    // second divider bank: sub-slice count and slice within cycle
    logic [DIV_NW-1:0] w_lc_quo, w_cs_quo;
    logic [DIV_DW-1:0] w_lc_rem, w_cs_rem;

    stc_div u_div_logic (
        .i_clk (i_clk), .i_en (w_adv),
        .i_num (DIV_NW'(w_ta_rem)), .i_den (w_lperiod),
        .o_quo (w_lc_quo), .o_rem (w_lc_rem)
    );
    stc_div u_div_cycle (
        .i_clk (i_clk), .i_en (w_adv),
        .i_num (w_ta_quo), .i_den (DIV_DW'(w_nsl)),
        .o_quo (w_cs_quo), .o_rem (w_cs_rem)
    );

    t_side_b r_side_b [D];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side_b[0] <= n_side_b;
            for (int k = 1; k < D; k++) begin
                r_side_b[k] <= r_side_b[k-1];
            end
        end
    end

    // output stage: clamp the count, combine with whole slices
    logic [POR_W-1:0]     w_npo_m1;
    logic [POR_W-1:0]     w_cnt;
    logic [ABSL_W:0]      w_abs_l;
    logic [CLS_W:0]       w_cyc_l;
    logic [START_W:0]     w_lstart;
    logic [PER_W-1:0]     r_o_tis;
    logic [TIME_BITS-1:0] r_o_abs;
    logic [CSL_W-1:0]     r_o_cyc;
    logic [ABSL_W-1:0]    r_o_absl;
    logic [CLS_W-1:0]     r_o_cycl;
    logic                 r_o_reconf;
    logic                 r_o_cross;
    logic [START_W-1:0]   r_o_sstart;
    logic [START_W-1:0]   r_o_lstart;
    logic [CSL_W-1:0]     r_o_wsl;
    logic [CLS_W-1:0]     r_o_wlsl;

    always_comb begin
        w_npo_m1 = w_npo - POR_W'(1);
        w_cnt    = (w_lc_quo > DIV_NW'(w_npo_m1)) ? w_npo_m1 : w_lc_quo[POR_W-1:0];
        w_abs_l  = (ABSL_W+1)'(r_side_b[D-1].abs_slice) * (ABSL_W+1)'(w_npo)
                   + (ABSL_W+1)'(w_cnt);
        // the clamped count stays below portions, so the wrap splits cleanly
        w_cyc_l  = (CLS_W+1)'(w_cs_rem[CSL_W-1:0]) * (CLS_W+1)'(w_npo) + (CLS_W+1)'(w_cnt);
        w_lstart = (START_W+1)'(r_side_b[D-1].lstart_hi)
                   + (START_W+1)'(r_side_b[D-1].lstart_lo);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_tis    <= r_side_b[D-1].time_in_slice;
            r_o_abs    <= r_side_b[D-1].abs_slice;
            r_o_cyc    <= w_cs_rem[CSL_W-1:0];
            r_o_absl   <= w_abs_l[ABSL_W-1:0];
            r_o_cycl   <= w_cyc_l[CLS_W-1:0];
            r_o_reconf <= r_side_b[D-1].in_reconfig;
            r_o_cross  <= r_side_b[D-1].crosses_slice;
            r_o_sstart <= r_side_b[D-1].slice_start;
            r_o_lstart <= w_lstart[START_W-1:0];
            r_o_wsl    <= r_side_b[D-1].wrapped_slice;
            r_o_wlsl   <= r_side_b[D-1].wrapped_logic;
        end
    end

    assign o_result.valid               = r_vld[VLD_LAST];
    assign o_result.time_in_slice       = r_o_tis;
    assign o_result.abs_slice           = r_o_abs;
    assign o_result.cycle_slice         = r_o_cyc;
    assign o_result.abs_logic_slice     = r_o_absl;
    assign o_result.cycle_logic_slice   = r_o_cycl;
    assign o_result.in_reconfig         = r_o_reconf;
    assign o_result.crosses_slice       = r_o_cross;
    assign o_result.slice_start_ps      = r_o_sstart;
    assign o_result.logic_start_ps      = r_o_lstart;
    assign o_result.wrapped_slice       = r_o_wsl;
    assign o_result.wrapped_logic_slice = r_o_wlsl;

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> r_vld == '0)
        else $error("valid bits not cleared by reset");

    a_tis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[VLD_LAST] |-> r_o_tis < w_period)
        else $error("time in slice not below period");

    a_cyc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[VLD_LAST] |-> CNT_W'(r_o_cyc) < w_nsl)
        else $error("cycle slice not below slice count");

    a_cycl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[VLD_LAST] |-> NL_W'(r_o_cycl) < w_nlogic)
        else $error("cycle logic slice not below logic slice count");
endmodule
`default_nettype wire

[dv/testbench.sv]
// Testbench for the slice time calculator: drives query transfers with random
// gaps, predicts each result from the schedule registers, checks in order.
// Depends on stc_pkg, stc_query_if, stc_result_if and slice_time_calculator_unit.
`default_nettype none
module testbench;
    import stc_pkg::*;

    localparam int LATENCY     = 2 * TIME_BITS + 1;
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 400;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [PER_W-1:0]     time_in_slice;
        logic [TIME_BITS-1:0] abs_slice;
        logic [CSL_W-1:0]     cycle_slice;
        logic [ABSL_W-1:0]    abs_logic_slice;
        logic [CLS_W-1:0]     cycle_logic_slice;
        logic                 in_reconfig;
        logic                 crosses_slice;
        logic [START_W-1:0]   slice_start_ps;
        logic [START_W-1:0]   logic_start_ps;
        logic [CSL_W-1:0]     wrapped_slice;
        logic [CLS_W-1:0]     wrapped_logic_slice;
    } t_lookup;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    stc_query_if  query_ch ();
    stc_result_if result_ch ();

    slice_time_calculator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_query    (query_ch.sink),
        .o_result   (result_ch.source)
    );

    // schedule register shadow
    logic [63:0] period_reg, connected_reg, lperiod_reg, nslice_reg, nportion_reg;

    t_lookup lookups_due[$];
    int      errors;
    int      idle_cycles;
    bit      idle_enable;
    bit      hold_off;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic t_lookup predict_lookup(logic [47:0] t, logic [31:0] off,
                                               logic [23:0] sn);
        t_lookup     r;
        logic [63:0] per, lper, nsl, npo, nlog, rel, abs_s, cnt, abs_l, later;
        per  = (period_reg == 0) ? 64'd1 : period_reg;
        lper = (lperiod_reg == 0) ? 64'd1 : lperiod_reg;
        nsl  = (nslice_reg == 0) ? 64'd1 : nslice_reg;
        npo  = (nportion_reg == 0) ? 64'd1 : nportion_reg;
        if (nsl > MAX_SLICES) nsl = MAX_SLICES;
        if (npo > PORTION_LIMIT) npo = PORTION_LIMIT;
        nlog  = nsl * npo;
        rel   = {16'd0, t} % per;
        abs_s = {16'd0, t} / per;
        cnt   = rel / lper;
        if (cnt > npo - 1) cnt = npo - 1;
        abs_l = abs_s * npo + cnt;
        later = ({16'd0, t} + {32'd0, off}) / per;
        r.time_in_slice       = rel[PER_W-1:0];
        r.abs_slice           = abs_s[TIME_BITS-1:0];
        r.cycle_slice         = CSL_W'(abs_s % nsl);
        r.abs_logic_slice     = abs_l[ABSL_W-1:0];
        r.cycle_logic_slice   = CLS_W'(abs_l % nlog);
        r.in_reconfig         = rel > connected_reg;
        r.crosses_slice       = later != abs_s;
        r.slice_start_ps      = START_W'({40'd0, sn} * per);
        r.logic_start_ps      = START_W'(({40'd0, sn} / npo) * per
                                         + ({40'd0, sn} % npo) * lper);
        r.wrapped_slice       = CSL_W'({40'd0, sn} % nsl);
        r.wrapped_logic_slice = CLS_W'({40'd0, sn} % nlog);
        return r;
    endfunction

    function automatic bit coin();
        return idle_enable && ($urandom_range(99) < 14);
    endfunction

    // receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= !hold_off && !coin();
        end
    end

    always @(posedge i_clk) begin
        t_lookup got, want;
        if (i_rst_n && (query_ch.valid && query_ch.ready
                        || result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > IDLE_LIMIT) begin
            $display("[slice_time_calculator_unit] ERROR");
            $finish;
        end
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got = '{result_ch.time_in_slice, result_ch.abs_slice, result_ch.cycle_slice,
                    result_ch.abs_logic_slice, result_ch.cycle_logic_slice,
                    result_ch.in_reconfig, result_ch.crosses_slice,
                    result_ch.slice_start_ps, result_ch.logic_start_ps,
                    result_ch.wrapped_slice, result_ch.wrapped_logic_slice};
            if (lookups_due.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                want = lookups_due.pop_front();
                if (got.time_in_slice !== want.time_in_slice) begin
                    $error("time_in_slice exp %0d got %0d", want.time_in_slice,
                           got.time_in_slice); errors++; end
                if (got.abs_slice !== want.abs_slice) begin
                    $error("abs_slice exp %0d got %0d", want.abs_slice,
                           got.abs_slice); errors++; end
                if (got.cycle_slice !== want.cycle_slice) begin
                    $error("cycle_slice exp %0d got %0d", want.cycle_slice,
                           got.cycle_slice); errors++; end
                if (got.abs_logic_slice !== want.abs_logic_slice) begin
                    $error("abs_logic_slice exp %0d got %0d", want.abs_logic_slice,
                           got.abs_logic_slice); errors++; end
                if (got.cycle_logic_slice !== want.cycle_logic_slice) begin
                    $error("cycle_logic_slice exp %0d got %0d", want.cycle_logic_slice,
                           got.cycle_logic_slice); errors++; end
                if (got.in_reconfig !== want.in_reconfig) begin
                    $error("in_reconfig exp %0d got %0d", want.in_reconfig,
                           got.in_reconfig); errors++; end
                if (got.crosses_slice !== want.crosses_slice) begin
                    $error("crosses_slice exp %0d got %0d", want.crosses_slice,
                           got.crosses_slice); errors++; end
                if (got.slice_start_ps !== want.slice_start_ps) begin
                    $error("slice_start_ps exp %0d got %0d", want.slice_start_ps,
                           got.slice_start_ps); errors++; end
                if (got.logic_start_ps !== want.logic_start_ps) begin
                    $error("logic_start_ps exp %0d got %0d", want.logic_start_ps,
                           got.logic_start_ps); errors++; end
                if (got.wrapped_slice !== want.wrapped_slice) begin
                    $error("wrapped_slice exp %0d got %0d", want.wrapped_slice,
                           got.wrapped_slice); errors++; end
                if (got.wrapped_logic_slice !== want.wrapped_logic_slice) begin
                    $error("wrapped_logic_slice exp %0d got %0d",
                           want.wrapped_logic_slice, got.wrapped_logic_slice); errors++; end
            end
        end
    end

    // offer one query; hold valid until the transfer, then predict
    task automatic send_query(logic [47:0] t, logic [31:0] off, logic [23:0] sn);
        while (coin()) begin
            query_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        query_ch.valid        <= 1'b1;
        query_ch.time_ps      <= t;
        query_ch.offset_ps    <= off;
        query_ch.slice_number <= sn;
        @(posedge i_clk);
        while (!query_ch.ready) @(posedge i_clk);
        lookups_due.insert(lookups_due.size(), predict_lookup(t, off, sn));
        @(negedge i_clk);
    endtask

    task automatic drain();
        query_ch.valid <= 1'b0;
        while (lookups_due.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SLICE_PERIOD: period_reg    = value[PER_W-1:0];
            CFG_CONNECTED:    connected_reg = value[PER_W-1:0];
            CFG_LOGIC_PERIOD: lperiod_reg   = value[PER_W-1:0];
            CFG_SLICE_COUNT:  nslice_reg    = value[CNT_W-1:0];
            CFG_PORTION_CNT:  nportion_reg  = value[POR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic schedule(logic [63:0] per, logic [63:0] conn, logic [63:0] lper,
                            logic [63:0] nsl, logic [63:0] npo);
        drain();
        write_reg(CFG_SLICE_PERIOD, per);
        write_reg(CFG_CONNECTED, conn);
        write_reg(CFG_LOGIC_PERIOD, lper);
        write_reg(CFG_SLICE_COUNT, nsl);
        write_reg(CFG_PORTION_CNT, npo);
    endtask

    function automatic logic [47:0] rand_time();
        case ($urandom_range(3))
            0: return 48'($urandom_range(5_000_000));
            1: return {16'($urandom), 32'($urandom)};
            2: return {16'hffff, 32'($urandom)};
            default: return {8'($urandom_range(255)), 40'($urandom)};
        endcase
    endfunction

    function automatic logic [31:0] rand_offset();
        return $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(2_000_000));
    endfunction

    task automatic random_queries(int count);
        repeat (count) begin
            send_query(rand_time(), rand_offset(), 24'($urandom));
        end
    endtask

    task automatic test_reset_schedule();
        send_query('0, '0, '0);
        send_query('1, '1, '1);
        send_query(48'd900_000, 32'd0, 24'd7);
        send_query(48'd900_001, 32'd99_998, 24'd8);
        send_query(48'd999_999, 32'd1, 24'd9);
        send_query(48'd2_650_000, 32'd349_999, 24'd123_456);
    endtask

    task automatic test_zero_and_saturation();
        // zero periods and counts act as 1, oversize counts saturate
        schedule(0, 0, 0, 0, 0);
        send_query(48'd12345, 32'd0, 24'd77);
        send_query('1, '1, '1);
        schedule(64'd1000, 64'd1000, 64'd7, 64'h1fff, 64'h1ff);
        send_query(48'd999, 32'd1, 24'hffffff);
        send_query(48'd1000, 32'd0, 24'd65535);
        send_query('1, '1, '1);
        schedule(64'hf_ffff_ffff, 64'hf_ffff_fffe, 64'hf_ffff_ffff, 64'd4096, 64'd256);
        send_query('1, '1, '1);
        send_query(48'hf_ffff_fffe, 32'd1, 24'hffffff);
        send_query(48'hf_ffff_ffff, 32'd0, 24'd255);
        schedule(64'd1, 64'd0, 64'd1, 64'd4097, 64'd257);
        send_query(48'd5, 32'd0, 24'd1000);
        send_query(48'hffff_ffff_fffe, 32'd1, 24'hffffff);
        drain();
        write_reg(CFG_UNUSED, 64'd55); // unknown index is ignored
        send_query(48'd77, 32'd3, 24'd12);
    endtask

    task automatic test_random_schedules();
        repeat (8) begin
            schedule($urandom_range(1) ? 64'($urandom_range(1, 5_000_000))
                                       : {28'd0, 4'($urandom), 32'($urandom)},
                     {28'd0, 4'($urandom), 32'($urandom)} >> $urandom_range(35),
                     $urandom_range(1) ? 64'($urandom_range(0, 2_000_000))
                                       : {28'd0, 4'($urandom), 32'($urandom)},
                     64'($urandom_range(0, 8191)), 64'($urandom_range(0, 511)));
            random_queries(150);
        end
    endtask

    task automatic test_backpressure();
        schedule(64'd1_000_000, 64'd900_000, 64'd300_000, 64'd8, 64'd4);
        fork
            begin
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off = 1'b0;
            end
            random_queries(150);
        join
        idle_enable = 1'b0; // full-rate stretch
        random_queries(150);
        idle_enable = 1'b1;
    endtask

    initial begin
        errors      = 0;
        idle_cycles = 0;
        idle_enable = 1'b1;
        hold_off    = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        query_ch.valid        = 1'b0;
        query_ch.time_ps      = '0;
        query_ch.offset_ps    = '0;
        query_ch.slice_number = '0;
        period_reg    = 64'd1_000_000;
        connected_reg = 64'd900_000;
        lperiod_reg   = 64'd300_000;
        nslice_reg    = 64'd8;
        nportion_reg  = 64'd1;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_schedule();
        test_zero_and_saturation();
        test_backpressure();
        test_random_schedules();
        drain();
        if (errors == 0) begin
            $display("[slice_time_calculator_unit] OK");
        end else begin
            $display("[slice_time_calculator_unit] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
